// ===== hw/rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the stride prefetch detector.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int ADDR_BITS   = 48;
  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int MAX_LINES   = 8;
  localparam int MAX_MATCH   = 8;

  localparam int STRIDE_W = 13;
  localparam int DEPTH_W  = 4;
  localparam int LOOK_W   = 8;
  localparam int LINES_W  = 4;
  localparam int SHIFT_W  = 4;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;

  // Line counter holds 0 .. MAX_LINES.
  localparam int K_W = $clog2(MAX_LINES + 1);

  // Offset in lines is lookahead plus line number; shifted by up to 15 bits.
  localparam int OFFL_W = LOOK_W + 1;
  localparam int OFF_W  = OFFL_W + (1 << SHIFT_W) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_STRIDE       = 3'd0,
    CFG_MATCH_DEPTH       = 3'd1,
    CFG_LOOKAHEAD_LINES   = 3'd2,
    CFG_LINES_PER_TRIGGER = 3'd3,
    CFG_LINE_SHIFT        = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // Effective configuration, with depth and line count already saturated.
  typedef struct packed {
    logic [STRIDE_W-1:0] base_stride;
    logic [DEPTH_W-1:0]  depth;
    logic [LOOK_W-1:0]   lookahead;
    logic [LINES_W-1:0]  lines;
    logic [SHIFT_W-1:0]  line_shift;
  } cfg_t;

  typedef struct packed {
    logic           accept;     // load access address, start single-stride pass
    logic           pass_dbl;   // restart the walk with double stride
    logic           step;       // move candidate one stride further back
    logic           commit;     // update the table
    logic           found;      // stride detected for this transaction
    logic           load_out;   // load output register with line out_k
    logic [K_W-1:0] out_k;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;                  // candidate address is in the table
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/stride_prefetch_detector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stride_prefetch_detector_core
// Stride detector that turns demand accesses into prefetch line addresses.
// ----------------------------------------------------------------------------
// Usage:
// Each demand access arrives as one transaction on the in_ stream: the byte
// address in in_tdata and the prefetch / already-issued flags in in_tuser.
// Transactions carrying either flag, or arriving while lines_per_trigger is
// zero, are accepted and leave no trace. Any other access walks the
// recent-address table backward one strided address per cycle, first with
// the base stride and then, if that fails, with the double stride; the check
// is skipped when match_depth is zero. A commit state then updates the table.
// On a detection the prefetch addresses leave on the out_ stream one per
// cycle while out_tready is high, the last one flagged with out_tlast; the
// first one is loaded into the output register in the commit state. The next
// access is taken once the last prefetch transaction has been accepted, or
// after the commit state without detection. A stall on out_tready simply
// holds the current prefetch address. Reset clears every table valid bit,
// the FIFO pointer and restores the default configuration. The user must
// make configuration writes only while idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module stride_prefetch_detector_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream. tdata: access_addr[47:0]. tuser: is_prefetch, already_issued.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [spd_pkg::ADDR_BITS-1:0]    in_tdata,
  input  wire logic [1:0]                       in_tuser,
  // Result stream. tdata: prefetch_addr[47:0]. tlast: last_prefetch.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [spd_pkg::ADDR_BITS-1:0]         out_tdata,
  output logic                                  out_tlast,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  spd_pkg::cfg_t       cfg;
  spd_pkg::ctrl_cmd_t  cmd;
  spd_pkg::dp_status_t status;

  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The sequencer owns the handshakes and the stride and line counters.
  spd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_flags   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the table, the candidate address and the output register.
  spd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_addr  (in_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_addr (out_tdata),
    .out_last (out_tlast)
  );

  // The block never takes an access while a prefetch address is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a result is pending");

  // A flagged access is dropped and the block stays ready.
  a_flag_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser != 2'b00)) |=> (in_tready && !out_tvalid))
    else $error("flagged access was processed");

  // After the final prefetch of a run the result stream goes quiet.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after final prefetch of a run");

  // A table commit only happens on behalf of an accepted access.
  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!in_tready && !out_tvalid))
    else $error("table commit outside of a transaction");

endmodule
`default_nettype wire

// ===== hw/rtl/spd_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_cfg_regs
// Configuration registers with saturation of match depth and line count.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output spd_pkg::cfg_t                         cfg
);

  logic [spd_pkg::STRIDE_W-1:0] base_stride_r;
  logic [spd_pkg::DEPTH_W-1:0]  match_depth_r;
  logic [spd_pkg::LOOK_W-1:0]   lookahead_r;
  logic [spd_pkg::LINES_W-1:0]  lines_r;
  logic [spd_pkg::SHIFT_W-1:0]  line_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_stride_r <= spd_pkg::STRIDE_W'(64);
      match_depth_r <= spd_pkg::DEPTH_W'(2);
      lookahead_r   <= spd_pkg::LOOK_W'(1);
      lines_r       <= spd_pkg::LINES_W'(2);
      line_shift_r  <= spd_pkg::SHIFT_W'(6);
    end else if (cfg_we) begin
      case (spd_pkg::cfg_idx_e'(cfg_index))
        spd_pkg::CFG_BASE_STRIDE:       base_stride_r <= cfg_wdata[spd_pkg::STRIDE_W-1:0];
        spd_pkg::CFG_MATCH_DEPTH:       match_depth_r <= cfg_wdata[spd_pkg::DEPTH_W-1:0];
        spd_pkg::CFG_LOOKAHEAD_LINES:   lookahead_r   <= cfg_wdata[spd_pkg::LOOK_W-1:0];
        spd_pkg::CFG_LINES_PER_TRIGGER: lines_r       <= cfg_wdata[spd_pkg::LINES_W-1:0];
        spd_pkg::CFG_LINE_SHIFT:        line_shift_r  <= cfg_wdata[spd_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.base_stride = base_stride_r;
    cfg.depth       = (match_depth_r > spd_pkg::MAX_MATCH) ?
                      spd_pkg::DEPTH_W'(spd_pkg::MAX_MATCH) : match_depth_r;
    cfg.lookahead   = lookahead_r;
    cfg.lines       = (lines_r > spd_pkg::MAX_LINES) ?
                      spd_pkg::LINES_W'(spd_pkg::MAX_LINES) : lines_r;
    cfg.line_shift  = line_shift_r;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_ctrl
// Sequencer: stride walk over the table, table commit and prefetch emission.
// ----------------------------------------------------------------------------
module spd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  spd_pkg::cfg_t       cfg,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [1:0]     in_flags,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  spd_pkg::dp_status_t status,
  output spd_pkg::ctrl_cmd_t  cmd
);

  spd_pkg::state_t                state_r, state_nxt;
  logic [spd_pkg::DEPTH_W-1:0]    i_r, i_nxt;
  logic                           pass_r, pass_nxt;
  logic                           found_r, found_nxt;
  logic [spd_pkg::K_W-1:0]        k_r, k_nxt;
  logic                           last_line;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spd_pkg::ST_IDLE;
      i_r     <= '0;
      pass_r  <= 1'b0;
      found_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      pass_r  <= pass_nxt;
      found_r <= found_nxt;
      k_r     <= k_nxt;
    end
  end

  assign last_line = ((spd_pkg::K_W + 1)'(k_r) + (spd_pkg::K_W + 1)'(1)) ==
                     (spd_pkg::K_W + 1)'(cfg.lines);

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    pass_nxt   = pass_r;
    found_nxt  = found_r;
    k_nxt      = k_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    cmd.found  = found_r;
    cmd.out_k  = k_r;

    case (state_r)
      spd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (cfg.lines != '0) && (in_flags == 2'b00)) begin
          cmd.accept = 1'b1;
          pass_nxt   = 1'b0;
          i_nxt      = spd_pkg::DEPTH_W'(1);
          if (cfg.depth == '0) begin
            // Empty test: a single stride is always detected.
            found_nxt = 1'b1;
            state_nxt = spd_pkg::ST_COMMIT;
          end else begin
            state_nxt = spd_pkg::ST_CHECK;
          end
        end
      end

      spd_pkg::ST_CHECK: begin
        if (status.hit) begin
          if (i_r == cfg.depth) begin
            found_nxt = 1'b1;
            state_nxt = spd_pkg::ST_COMMIT;
          end else begin
            cmd.step = 1'b1;
            i_nxt    = i_r + spd_pkg::DEPTH_W'(1);
          end
        end else if (!pass_r) begin
          cmd.pass_dbl = 1'b1;
          pass_nxt     = 1'b1;
          i_nxt        = spd_pkg::DEPTH_W'(1);
        end else begin
          found_nxt = 1'b0;
          state_nxt = spd_pkg::ST_COMMIT;
        end
      end

      spd_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        if (found_r) begin
          cmd.load_out = 1'b1;
          cmd.out_k    = '0;
          k_nxt        = '0;
          state_nxt    = spd_pkg::ST_EMIT;
        end else begin
          state_nxt = spd_pkg::ST_IDLE;
        end
      end

      spd_pkg::ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (last_line) begin
            state_nxt = spd_pkg::ST_IDLE;
          end else begin
            k_nxt        = k_r + spd_pkg::K_W'(1);
            cmd.load_out = 1'b1;
            cmd.out_k    = k_r + spd_pkg::K_W'(1);
          end
        end
      end

      default: begin
        state_nxt = spd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_datapath
// Recent-address table, candidate walk and prefetch address generation.
// ----------------------------------------------------------------------------
module spd_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  spd_pkg::cfg_t                       cfg,
  input  wire logic [spd_pkg::ADDR_BITS-1:0]  in_addr,
  input  spd_pkg::ctrl_cmd_t                  cmd,
  output spd_pkg::dp_status_t                 status,
  output logic [spd_pkg::ADDR_BITS-1:0]       out_addr,
  output logic                                out_last
);

  localparam int AW = spd_pkg::ADDR_BITS;
  localparam int TD = spd_pkg::TABLE_DEPTH;

  logic [AW-1:0]                  ent_r [TD];
  logic [TD-1:0]                  valid_r;
  logic [spd_pkg::SLOT_W-1:0]     slot_r;

  logic [AW-1:0]                  addr_r;
  logic [AW-1:0]                  cand_r;
  logic [AW-1:0]                  stride_r;
  logic [AW-1:0]                  out_addr_r;
  logic                           out_last_r;

  logic [AW-1:0]                  base_ext;
  logic [AW-1:0]                  dbl_ext;
  logic [AW-1:0]                  inv_addr;
  logic [TD-1:0]                  hit_vec;
  logic [TD-1:0]                  valid_nxt;
  logic [spd_pkg::OFFL_W-1:0]     off_lines;
  logic [spd_pkg::OFF_W-1:0]      off_bytes;

  assign base_ext = AW'(cfg.base_stride);
  assign dbl_ext  = AW'({cfg.base_stride, 1'b0});

  // With zero match depth the run ends at the access address itself.
  assign inv_addr = (cfg.depth == '0) ? addr_r : cand_r;

  always_comb begin
    for (int s = 0; s < TD; s++) begin
      hit_vec[s] = valid_r[s] && (ent_r[s] == cand_r);
    end
  end
  assign status.hit = |hit_vec;

  // Write at the FIFO slot first, then invalidate the oldest address of the run.
  always_comb begin
    for (int s = 0; s < TD; s++) begin
      logic          wr;
      logic [AW-1:0] nval;
      wr           = (spd_pkg::SLOT_W'(s) == slot_r);
      nval         = wr ? addr_r : ent_r[s];
      valid_nxt[s] = (wr || valid_r[s]) && !(cmd.found && (nval == inv_addr));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      slot_r  <= '0;
    end else if (cmd.commit) begin
      valid_r <= valid_nxt;
      slot_r  <= (slot_r == spd_pkg::SLOT_W'(TD - 1)) ? '0 :
                 slot_r + spd_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ent_r[slot_r] <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r   <= in_addr;
      cand_r   <= in_addr - base_ext;
      stride_r <= base_ext;
    end else if (cmd.pass_dbl) begin
      cand_r   <= addr_r - dbl_ext;
      stride_r <= dbl_ext;
    end else if (cmd.step) begin
      cand_r   <= cand_r - stride_r;
    end
  end

  assign off_lines = spd_pkg::OFFL_W'(cfg.lookahead) + spd_pkg::OFFL_W'(cmd.out_k);
  assign off_bytes = spd_pkg::OFF_W'(off_lines) << cfg.line_shift;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_addr_r <= addr_r + AW'(off_bytes);
      out_last_r <= ((spd_pkg::K_W + 1)'(cmd.out_k) + (spd_pkg::K_W + 1)'(1)) ==
                    (spd_pkg::K_W + 1)'(cfg.lines);
    end
  end

  assign out_addr = out_addr_r;
  assign out_last = out_last_r;

endmodule
`default_nettype wire
